// File: hdl/midi_note_arpeggiator_defines.svh
// ----------------------------------------------------------------------------
// midi_note_arpeggiator assertion macros
// concurrent checks sampled on clk, held off during rst
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_ARPEGGIATOR_DEFINES_SVH
`define MIDI_NOTE_ARPEGGIATOR_DEFINES_SVH

// same-cycle implication
`define ARP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// request and response types and command codes of the up-arpeggiator
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

  localparam logic [1:0] CMD_NOTE_ON   = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF  = 2'd1;
  localparam logic [1:0] CMD_BLOCK_END = 2'd2;

  localparam logic [15:0] NOTE_DURATION_RESET = 16'd6615;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  note;
    logic [12:0] block_samples;
  } req_t;

  typedef struct packed {
    logic        is_note_on;
    logic [6:0]  out_note;
    logic [11:0] sample_offset;
    logic        last_of_run;
  } rsp_t;

endpackage

`default_nettype wire

// File: hdl/midi_note_arpeggiator.sv
// ----------------------------------------------------------------------------
// midi_note_arpeggiator
// up-arpeggiator: sorted set of held notes in a small memory, stepped by a
// sample timer that advances on end-of-block requests
// ----------------------------------------------------------------------------
// The block takes one request at a time; req_stall is high while a request is
// in progress. A note-on or note-off walks the held-note memory through its
// single read and single write port, one entry per cycle: a search up to the
// note's place, then a shift of the entries above it; an empty or full store
// or an unknown command needs no walk.
// An end-of-block request runs the sample timer through a bit-serial
// remainder unit, and on a step a second pass of that unit picks the next
// note, then one memory read; the response side can hold this up. The last
// response stays in the output register while the next request is taken.
`default_nettype none
`include "midi_note_arpeggiator_defines.svh"

module midi_note_arpeggiator #(
  parameter int MAX_NOTES         = 16,
  parameter int MAX_BLOCK_SAMPLES = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output      logic          req_stall,
  input  wire arp_pkg::req_t req,
  output      logic          rsp_valid,
  input  wire logic          rsp_stall,
  output      arp_pkg::rsp_t rsp,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_data
);

  localparam int IW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CW = $clog2(MAX_NOTES + 1);
  localparam int DW = 17;

  typedef enum logic [9:0] {
    ST_IDLE      = 10'b00_0000_0001,
    ST_SEARCH    = 10'b00_0000_0010,
    ST_INS_SHIFT = 10'b00_0000_0100,
    ST_REM_SHIFT = 10'b00_0000_1000,
    ST_CALC      = 10'b00_0001_0000,
    ST_TIMER_DIV = 10'b00_0010_0000,
    ST_NOTE_OFF  = 10'b00_0100_0000,
    ST_STEP_DIV  = 10'b00_1000_0000,
    ST_STEP_RD   = 10'b01_0000_0000,
    ST_NOTE_ON   = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  logic [6:0]    held_notes [MAX_NOTES];
  logic [6:0]    rd_q;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [6:0]    mem_wdata;
  logic [IW-1:0] mem_raddr;

  logic [15:0]   note_duration;
  logic [CW-1:0] held_count;
  logic [IW-1:0] step_index;
  logic          sounding_valid;
  logic [6:0]    sounding_note;
  logic [15:0]   sample_timer;

  logic          op_ins;
  logic [6:0]    key;
  logic [IW-1:0] chk;
  logic [6:0]    carry;
  logic [12:0]   n_q;
  logic [15:0]   dur_q;
  logic          cross_q;
  logic [11:0]   off_q;

  logic [DW-1:0] div_q;
  logic [15:0]   rem_q;
  logic [15:0]   divisor_q;
  logic [4:0]    dcnt;

  logic          req_take;
  logic          out_free;
  logic [CW-1:0] chk_p1;
  logic [CW-1:0] chk_p2;
  logic [CW-1:0] step_p1;
  logic [16:0]   trial;
  logic [15:0]   rem_step;
  logic [16:0]   sum;
  logic [15:0]   diff;
  logic [12:0]   lim;
  logic [12:0]   off_calc;
  logic [12:0]   n_sat;
  logic [15:0]   dur_eff;

  logic          block_take;
  logic          on_out;
  logic          on_ok;
  logic          off_mid;

  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign chk_p1    = CW'(chk) + CW'(1);
  assign chk_p2    = CW'(chk) + CW'(2);
  assign step_p1   = CW'(step_index) + CW'(1);

  // shared bit-serial remainder step
  always_comb begin
    trial = {rem_q, div_q[DW-1]};
    if (trial >= {1'b0, divisor_q}) begin
      rem_step = 16'(trial - {1'b0, divisor_q});
    end else begin
      rem_step = trial[15:0];
    end
  end

  always_comb begin
    n_sat   = (32'(req.block_samples) > MAX_BLOCK_SAMPLES) ? 13'(MAX_BLOCK_SAMPLES)
                                                           : req.block_samples;
    dur_eff = (note_duration == 16'd0) ? 16'd1 : note_duration;
    sum     = {1'b0, sample_timer} + {4'b0, n_q};
    diff    = dur_q - sample_timer;
    lim     = n_q - 13'd1;
    if (n_q == 13'd0 || sample_timer >= dur_q) begin
      off_calc = 13'd0;
    end else if (diff > {3'b0, lim}) begin
      off_calc = lim;
    end else begin
      off_calc = diff[12:0];
    end
  end

  // held-note memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      held_notes[mem_waddr] <= mem_wdata;
    end
    rd_q <= held_notes[mem_raddr];
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = chk;
    mem_wdata  = key;
    mem_raddr  = IW'(chk_p1);
    unique case (state)
      ST_IDLE: begin
        mem_raddr = '0;
        mem_waddr = '0;
        mem_wdata = req.note;
        if (req_take) begin
          case (req.cmd)
            arp_pkg::CMD_NOTE_ON: begin
              if (held_count == '0) begin
                mem_we = 1'b1;
              end else if (held_count != CW'(MAX_NOTES)) begin
                state_next = ST_SEARCH;
              end
            end
            arp_pkg::CMD_NOTE_OFF: begin
              if (held_count != '0) begin
                state_next = ST_SEARCH;
              end
            end
            arp_pkg::CMD_BLOCK_END: state_next = ST_CALC;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (op_ins) begin
          if (rd_q == key) begin
            state_next = ST_IDLE;
          end else if (rd_q > key) begin
            mem_we     = 1'b1;
            state_next = ST_INS_SHIFT;
          end else if (chk_p1 == held_count) begin
            mem_we     = 1'b1;
            mem_waddr  = IW'(chk_p1);
            state_next = ST_IDLE;
          end
        end else begin
          if (rd_q == key) begin
            state_next = (chk_p1 == held_count) ? ST_IDLE : ST_REM_SHIFT;
          end else if (chk_p1 == held_count) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_INS_SHIFT: begin
        mem_we    = 1'b1;
        mem_wdata = carry;
        if (CW'(chk) == held_count) begin
          state_next = ST_IDLE;
        end
      end
      ST_REM_SHIFT: begin
        mem_we    = 1'b1;
        mem_wdata = rd_q;
        mem_raddr = IW'(chk_p2);
        if (chk_p2 == held_count) begin
          state_next = ST_IDLE;
        end
      end
      ST_CALC: state_next = ST_TIMER_DIV;
      ST_TIMER_DIV: begin
        if (dcnt == 5'd1) begin
          state_next = cross_q ? ST_NOTE_OFF : ST_IDLE;
        end
      end
      ST_NOTE_OFF: begin
        if (!sounding_valid || out_free) begin
          state_next = (held_count != '0) ? ST_STEP_DIV : ST_IDLE;
        end
      end
      ST_STEP_DIV: begin
        if (dcnt == 5'd1) begin
          state_next = ST_STEP_RD;
        end
      end
      ST_STEP_RD: begin
        mem_raddr  = IW'(rem_q);
        state_next = ST_NOTE_ON;
      end
      ST_NOTE_ON: begin
        mem_raddr = IW'(rem_q);
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      note_duration  <= arp_pkg::NOTE_DURATION_RESET;
      held_count     <= '0;
      step_index     <= '0;
      sounding_valid <= 1'b0;
      sounding_note  <= '0;
      sample_timer   <= '0;
      rsp_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        note_duration <= cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_take && req.cmd == arp_pkg::CMD_NOTE_ON && held_count == '0) begin
            held_count <= CW'(1);
          end
        end
        ST_SEARCH: begin
          if (op_ins && rd_q != key && rd_q < key && chk_p1 == held_count) begin
            held_count <= held_count + CW'(1);
          end
          if (!op_ins && rd_q == key && chk_p1 == held_count) begin
            held_count <= held_count - CW'(1);
          end
        end
        ST_INS_SHIFT: begin
          if (CW'(chk) == held_count) begin
            held_count <= held_count + CW'(1);
          end
        end
        ST_REM_SHIFT: begin
          if (chk_p2 == held_count) begin
            held_count <= held_count - CW'(1);
          end
        end
        ST_TIMER_DIV: begin
          if (dcnt == 5'd1) begin
            sample_timer <= rem_step;
          end
        end
        ST_NOTE_OFF: begin
          if (sounding_valid && out_free) begin
            rsp_valid      <= 1'b1;
            sounding_valid <= 1'b0;
          end
        end
        ST_NOTE_ON: begin
          if (out_free) begin
            rsp_valid      <= 1'b1;
            sounding_valid <= 1'b1;
            sounding_note  <= rd_q;
            step_index     <= IW'(rem_q);
          end
        end
        ST_CALC, ST_STEP_DIV, ST_STEP_RD: begin
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        key    <= req.note;
        op_ins <= (req.cmd == arp_pkg::CMD_NOTE_ON);
        chk    <= '0;
        n_q    <= n_sat;
        dur_q  <= dur_eff;
      end
      ST_SEARCH: begin
        if (op_ins && rd_q > key) begin
          carry <= rd_q;
          chk   <= IW'(chk_p1);
        end else if (rd_q != key) begin
          chk <= IW'(chk_p1);
        end
      end
      ST_INS_SHIFT: begin
        carry <= rd_q;
        chk   <= IW'(chk_p1);
      end
      ST_REM_SHIFT: chk <= IW'(chk_p1);
      ST_CALC: begin
        cross_q   <= (sum >= {1'b0, dur_q});
        off_q     <= off_calc[11:0];
        div_q     <= sum;
        divisor_q <= dur_q;
        rem_q     <= '0;
        dcnt      <= 5'(DW);
      end
      ST_TIMER_DIV, ST_STEP_DIV: begin
        rem_q <= rem_step;
        div_q <= {div_q[DW-2:0], 1'b0};
        dcnt  <= dcnt - 5'd1;
      end
      ST_NOTE_OFF: begin
        div_q     <= {step_p1, {(DW - CW){1'b0}}};
        divisor_q <= 16'(held_count);
        rem_q     <= '0;
        dcnt      <= 5'(CW);
      end
      default: begin
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (state == ST_NOTE_OFF && sounding_valid && out_free) begin
      rsp.is_note_on    <= 1'b0;
      rsp.out_note      <= sounding_note;
      rsp.sample_offset <= off_q;
      rsp.last_of_run   <= (held_count == '0);
    end else if (state == ST_NOTE_ON && out_free) begin
      rsp.is_note_on    <= 1'b1;
      rsp.out_note      <= rd_q;
      rsp.sample_offset <= off_q;
      rsp.last_of_run   <= 1'b1;
    end
  end

  assign block_take = req_take && (req.cmd == arp_pkg::CMD_BLOCK_END);
  assign on_out     = rsp_valid && rsp.is_note_on;
  assign on_ok      = sounding_valid && (sounding_note == rsp.out_note);
  assign off_mid    = rsp_valid && !rsp.is_note_on && !rsp.last_of_run;

  `ARP_ASSERT_IMPLY(a_count_cap, 1'b1, held_count <= CW'(MAX_NOTES), "count above capacity")
  `ARP_ASSERT_IMPLY(a_on_matches_sounding, on_out, on_ok, "note-on differs from sounding note")
  `ARP_ASSERT_IMPLY(a_off_not_last, off_mid, held_count != '0, "note-off not last, none held")
  `ARP_ASSERT_NEXT(a_block_start, block_take, state == ST_CALC, "block end did not start")

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench for midi_note_arpeggiator
// drives note and end-of-block requests with random gaps and response stalls,
// predicts every note message from a behavioral copy of the arpeggiator and
// checks each response against the oldest predicted message
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int MAX_HELD        = 16;
  localparam int MAX_BLOCK       = 4096;
  localparam int SETTLE_CYCLES   = 60;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int MISMATCH_PRINTS = 10;

  // command code the block has no use for
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  arp_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  arp_pkg::rsp_t rsp;
  logic          cfg_we = 1'b0;
  logic [15:0]   cfg_data = '0;

  midi_note_arpeggiator #(
    .MAX_NOTES(MAX_HELD),
    .MAX_BLOCK_SAMPLES(MAX_BLOCK)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // arpeggiator state as predicted
  logic [6:0]    held_set [MAX_HELD];
  int            held_total = 0;
  int            step_pos = 0;
  bit            sounding_on = 1'b0;
  logic [6:0]    sounding_key = '0;
  int            timer_samples = 0;
  logic [15:0]   step_length = arp_pkg::NOTE_DURATION_RESET;
  arp_pkg::rsp_t expected_msgs [$];

  int  mismatch_count = 0;
  int  cycle_count = 0;
  bit  idle_enabled = 1'b1;
  int  sink_hold_cycles = 0;
  int  stall_left = 0;
  arp_pkg::rsp_t want;

  function automatic void hold_note(logic [6:0] n);
    int pos;
    int i;
    pos = 0;
    while (pos < held_total && held_set[pos] < n) pos++;
    if (pos < held_total && held_set[pos] == n) return;
    if (held_total >= MAX_HELD) return;
    for (i = held_total; i > pos; i--) held_set[i] = held_set[i - 1];
    held_set[pos] = n;
    held_total++;
  endfunction

  function automatic void drop_note(logic [6:0] n);
    int pos;
    int i;
    pos = 0;
    while (pos < held_total && held_set[pos] != n) pos++;
    if (pos >= held_total) return;
    for (i = pos; i + 1 < held_total; i++) held_set[i] = held_set[i + 1];
    held_total--;
  endfunction

  function automatic void predict_arpeggio(arp_pkg::req_t r);
    int            n;
    int            dur;
    int            off;
    int            k;
    int            i;
    arp_pkg::rsp_t msgs [2];
    k = 0;
    case (r.cmd)
      arp_pkg::CMD_NOTE_ON: hold_note(r.note);
      arp_pkg::CMD_NOTE_OFF: drop_note(r.note);
      arp_pkg::CMD_BLOCK_END: begin
        n = (r.block_samples > MAX_BLOCK) ? MAX_BLOCK : int'(r.block_samples);
        dur = (step_length == 16'd0) ? 1 : int'(step_length);
        if (timer_samples + n >= dur) begin
          off = dur - timer_samples;
          if (off > n - 1) off = n - 1;
          if (off < 0) off = 0;
          if (sounding_on) begin
            msgs[k].is_note_on = 1'b0;
            msgs[k].out_note = sounding_key;
            msgs[k].sample_offset = off[11:0];
            msgs[k].last_of_run = 1'b0;
            k++;
            sounding_on = 1'b0;
          end
          if (held_total > 0) begin
            step_pos = (step_pos + 1) % held_total;
            sounding_key = held_set[step_pos];
            sounding_on = 1'b1;
            msgs[k].is_note_on = 1'b1;
            msgs[k].out_note = sounding_key;
            msgs[k].sample_offset = off[11:0];
            msgs[k].last_of_run = 1'b0;
            k++;
          end
          if (k > 0) msgs[k - 1].last_of_run = 1'b1;
          for (i = 0; i < k; i++) expected_msgs.push_back(msgs[i]);
        end
        timer_samples = (timer_samples + n) % dur;
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_enabled) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic arp_pkg::req_t make_req(logic [1:0] cmd, logic [6:0] note,
                                             logic [12:0] samples);
    arp_pkg::req_t r;
    r.cmd = cmd;
    r.note = note;
    r.block_samples = samples;
    return r;
  endfunction

  function automatic arp_pkg::req_t random_request();
    arp_pkg::req_t r;
    int            pick;
    r = make_req(arp_pkg::CMD_BLOCK_END, 7'($urandom_range(127)), 13'($urandom_range(8191)));
    pick = $urandom_range(99);
    if (pick < 12) begin
      r.cmd = 2'($urandom_range(3));
    end else if (pick < 45) begin
      r.cmd = arp_pkg::CMD_NOTE_ON;
      if ($urandom_range(99) < 70) r.note = 7'($urandom_range(52, 75));
    end else if (pick < 65) begin
      r.cmd = arp_pkg::CMD_NOTE_OFF;
      if (held_total > 0 && $urandom_range(99) < 75)
        r.note = held_set[$urandom_range(held_total - 1)];
    end else begin
      pick = $urandom_range(99);
      if (pick < 60) r.block_samples = 13'($urandom_range(1, 64));
      else if (pick < 90) r.block_samples = 13'($urandom_range(1, 512));
      else r.block_samples = 13'($urandom_range(1, MAX_BLOCK));
    end
    return r;
  endfunction

  task automatic send_request(arp_pkg::req_t r);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    predict_arpeggio(r);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_duration(logic [15:0] value);
    wait_for_drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    step_length = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd8191));
    send_request(make_req(CMD_UNUSED, 7'd127, 13'd8191));
    send_request(make_req(arp_pkg::CMD_NOTE_ON, 7'd0, 13'd0));
    send_request(make_req(arp_pkg::CMD_NOTE_ON, 7'd127, 13'd0));
    send_request(make_req(arp_pkg::CMD_NOTE_ON, 7'd127, 13'd4096));
    send_request(make_req(arp_pkg::CMD_NOTE_OFF, 7'd64, 13'd0));
    repeat (3) send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd4096));
    send_request(make_req(arp_pkg::CMD_NOTE_OFF, 7'd0, 13'd0));
    send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd4096));
    send_request(make_req(arp_pkg::CMD_NOTE_OFF, 7'd127, 13'd0));
    repeat (2) send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd4096));
  endtask

  task automatic test_duration_extremes();
    write_duration(16'd1);
    send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd1));
    send_request(make_req(arp_pkg::CMD_NOTE_ON, 7'd5, 13'd0));
    send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd0));
    send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd1));
    write_duration(16'd0);
    send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd2));
    write_duration(16'd65535);
    repeat (3) send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd4096));
    // timer now far beyond the new step length
    write_duration(16'd100);
    send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd0));
    send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'd12));
  endtask

  task automatic test_full_store();
    int base;
    int i;
    write_duration(16'd50);
    base = $urandom_range(127);
    for (i = 0; i < 20; i++) begin
      send_request(make_req(arp_pkg::CMD_NOTE_ON, 7'(base + 7 * i), 13'd0));
      send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'($urandom_range(1, 64))));
    end
    for (i = 0; i < 10; i++) begin
      send_request(make_req(arp_pkg::CMD_NOTE_OFF, 7'(base + 14 * i), 13'd0));
      send_request(make_req(arp_pkg::CMD_NOTE_ON, 7'(base + 7 * $urandom_range(19)), 13'd0));
      send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'($urandom_range(1, 64))));
    end
  endtask

  task automatic test_output_backpressure();
    int i;
    write_duration(16'd1);
    for (i = 0; i < 3; i++)
      send_request(make_req(arp_pkg::CMD_NOTE_ON, 7'($urandom_range(127)), 13'd0));
    idle_enabled = 1'b0;
    sink_hold_cycles = 400;
    for (i = 0; i < 40; i++)
      send_request(make_req(arp_pkg::CMD_BLOCK_END, 7'd0, 13'($urandom_range(1, 8))));
    wait_for_drain();
    idle_enabled = 1'b1;
  endtask

  task automatic test_random_traffic();
    int phase;
    int i;
    int pause_at;
    logic [15:0] dur;
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: dur = arp_pkg::NOTE_DURATION_RESET;
        1: dur = 16'($urandom_range(2, 40));
        2: dur = 16'($urandom_range(40, 400));
        3: dur = 16'd1;
        4: dur = 16'($urandom_range(400, 4000));
        5: dur = 16'd0;
        6: dur = 16'($urandom_range(2, 200));
        7: dur = 16'd65535;
        8: dur = 16'($urandom_range(1, 65535));
        default: dur = 16'($urandom_range(10, 100));
      endcase
      write_duration(dur);
      idle_enabled = (phase % 4) != 3;
      pause_at = $urandom_range(20, 90);
      for (i = 0; i < 110; i++) begin
        if (i == pause_at) wait_for_drain();
        send_request(random_request());
      end
    end
    idle_enabled = 1'b1;
  endtask

  // response side stall pattern
  always @(negedge clk) begin
    if (sink_hold_cycles > 0) begin
      stall_left = sink_hold_cycles;
      sink_hold_cycles = 0;
    end
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else if (idle_enabled && $urandom_range(99) < 25) begin
      rsp_stall <= 1'b1;
      stall_left = pick_gap();
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  task automatic report_mismatch(string what, arp_pkg::rsp_t exp_msg);
    mismatch_count++;
    if (mismatch_count <= MISMATCH_PRINTS) begin
      $write("%s: expected on=%0d note=%0d offset=%0d last=%0d, ",
             what, exp_msg.is_note_on, exp_msg.out_note, exp_msg.sample_offset,
             exp_msg.last_of_run);
      $display("got on=%0d note=%0d offset=%0d last=%0d",
               rsp.is_note_on, rsp.out_note, rsp.sample_offset, rsp.last_of_run);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_msgs.size() == 0) begin
        report_mismatch("unexpected note message", '0);
      end else begin
        want = expected_msgs.pop_front();
        if (rsp.is_note_on !== want.is_note_on || rsp.out_note !== want.out_note ||
            rsp.sample_offset !== want.sample_offset || rsp.last_of_run !== want.last_of_run)
          report_mismatch("note message mismatch", want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_duration_extremes();
    test_full_store();
    test_output_backpressure();
    test_random_traffic();
    wait_for_drain();
    if (mismatch_count == 0 && expected_msgs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
